// ===== hdl/cdq_pkg.sv =====
// Shared constants, command and status codes, and payload types for the deque.
package cdq_pkg;

    localparam int DEPTH  = 8;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_REAR  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] entry_value;
    } cdq_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic [STAT_W-1:0] status;
        logic              is_empty_flag;
        logic              is_full_flag;
    } cdq_out_t;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic              shift_in;   // push at front: every cell takes its left neighbour
        logic              shift_out;  // pop at front: every cell takes its right neighbour
        logic              append;     // push at rear: first free cell loads the value
        logic              trim;       // pop at rear: last occupied cell empties
        logic [DATA_W-1:0] value;
    } cdq_ctrl_t;

endpackage

// ===== hdl/cdq_cell.sv =====
// One deque cell: a data word and its occupancy bit, linked to both neighbours.
module cdq_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cdq_pkg::cdq_ctrl_t        ctrl,
    input  logic [cdq_pkg::DATA_W-1:0] left_data,
    input  logic                      left_occ,
    input  logic [cdq_pkg::DATA_W-1:0] right_data,
    input  logic                      right_occ,
    input  logic [cdq_pkg::DATA_W-1:0] rear_in,
    output logic [cdq_pkg::DATA_W-1:0] data_q,
    output logic                      occ_q,
    output logic [cdq_pkg::DATA_W-1:0] rear_out
);

    logic [cdq_pkg::DATA_W-1:0] data_reg, data_next;
    logic                       occ_reg, occ_next;

    // Pick the next content from the broadcast operation and the neighbours
    always_comb begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (ctrl.shift_in) begin
            data_next = left_data;
            occ_next  = left_occ;
        end else if (ctrl.shift_out) begin
            data_next = right_data;
            occ_next  = right_occ;
        end else if (ctrl.append && !occ_reg && left_occ) begin
            data_next = ctrl.value;
            occ_next  = 1'b1;
        end else if (ctrl.trim && occ_reg && !right_occ) begin
            occ_next  = 1'b0;
        end
    end

    // Clear occupancy under reset; data needs none
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
        data_reg <= data_next;
    end

    // Pass the rear word towards the head of the row
    assign rear_out = (occ_reg && !right_occ) ? data_reg : rear_in;
    assign data_q   = data_reg;
    assign occ_q    = occ_reg;

endmodule

// ===== hdl/circular_deque.sv =====
// Deque of data words built as a row of shifting cells, with a registered result.
// The result of a request is written into the output register when the request is accepted.
// Throughput: one request per cycle unless the result side stalls; every cell updates in parallel from its neighbours.
// A new request is taken whenever the result register is empty or being drained.
// Reset (synchronous, active low) empties the deque and the result register;
// stored words are not cleared and are never read before being written.
module circular_deque (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cdq_pkg::cdq_in_t s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output cdq_pkg::cdq_out_t m_payload
);

    localparam int N = cdq_pkg::DEPTH;

    logic [cdq_pkg::DATA_W-1:0] cell_data [N];
    logic [cdq_pkg::DATA_W-1:0] cell_rear [N];
    logic [N-1:0]               cell_occ;

    cdq_pkg::cdq_ctrl_t ctrl;
    cdq_pkg::cdq_out_t  res;
    cdq_pkg::cdq_out_t  m_payload_reg;
    logic               m_valid_reg;
    logic               accept;
    logic               is_empty, is_full;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_empty = !cell_occ[0];
    assign is_full  = cell_occ[N-1];

    // Build the row of cells
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic [cdq_pkg::DATA_W-1:0] l_data, r_data, r_rear;
        logic                       l_occ, r_occ;
        if (i == 0) begin : g_head
            assign l_data = s_payload.entry_value;
            assign l_occ  = 1'b1;
        end else begin : g_mid_l
            assign l_data = cell_data[i-1];
            assign l_occ  = cell_occ[i-1];
        end
        if (i == N-1) begin : g_tail
            assign r_data = '0;
            assign r_occ  = 1'b0;
            assign r_rear = '0;
        end else begin : g_mid_r
            assign r_data = cell_data[i+1];
            assign r_occ  = cell_occ[i+1];
            assign r_rear = cell_rear[i+1];
        end
        cdq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .left_data  (l_data),
            .left_occ   (l_occ),
            .right_data (r_data),
            .right_occ  (r_occ),
            .rear_in    (r_rear),
            .data_q     (cell_data[i]),
            .occ_q      (cell_occ[i]),
            .rear_out   (cell_rear[i])
        );
    end

    // Decode the request into cell control and the result word
    always_comb begin
        ctrl                = '0;
        ctrl.value          = s_payload.entry_value;
        res.data_out        = '0;
        res.status          = cdq_pkg::ST_DONE;
        res.is_empty_flag   = is_empty;
        res.is_full_flag    = is_full;
        unique case (s_payload.command) inside
            cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
                if (is_full) begin
                    res.status = cdq_pkg::ST_FULL;
                end else begin
                    ctrl.shift_in     = accept && (s_payload.command == cdq_pkg::CMD_PUSH_FRONT);
                    ctrl.append       = accept && (s_payload.command == cdq_pkg::CMD_PUSH_REAR);
                    res.is_empty_flag = 1'b0;
                    res.is_full_flag  = cell_occ[N-2];
                end
            end
            cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
                if (is_empty) begin
                    res.status = cdq_pkg::ST_EMPTY;
                end else begin
                    ctrl.shift_out    = accept && (s_payload.command == cdq_pkg::CMD_POP_FRONT);
                    ctrl.trim         = accept && (s_payload.command == cdq_pkg::CMD_POP_REAR);
                    res.data_out      = (s_payload.command == cdq_pkg::CMD_POP_FRONT) ?
                                        cell_data[0] : cell_rear[0];
                    res.is_empty_flag = !cell_occ[1];
                    res.is_full_flag  = 1'b0;
                end
            end
            cdq_pkg::CMD_PEEK_FRONT, cdq_pkg::CMD_PEEK_REAR: begin
                if (is_empty) begin
                    res.status = cdq_pkg::ST_EMPTY;
                end else begin
                    res.data_out = (s_payload.command == cdq_pkg::CMD_PEEK_FRONT) ?
                                   cell_data[0] : cell_rear[0];
                end
            end
            default: begin
                res.status = cdq_pkg::ST_DONE;
            end
        endcase
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (accept) begin
            m_payload_reg <= res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// ===== tb/tb_circular_deque.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the circular deque: directed and random request streams.
module tb_circular_deque;

    // Command codes that the block does not define
    localparam logic [cdq_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [cdq_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int N_RANDOM   = 1724;
    localparam int N_QUIET    = 200;
    localparam int DRAIN_WAIT = 4;

    // Predicts each result from the requests accepted so far and checks arrivals in order
    class deque_scoreboard;
        logic [cdq_pkg::DATA_W-1:0] words[cdq_pkg::DEPTH];
        int                         front;
        int                         rear;
        bit                         empty;
        cdq_pkg::cdq_out_t          awaited_results[$];
        int                         errors;
        int                         n_push, n_pop, n_peek, n_spare;
        int                         n_refused_full, n_refused_empty;

        function new();
            front = 0;
            rear  = 0;
            empty = 1'b1;
            errors = 0;
            n_push = 0;
            n_pop = 0;
            n_peek = 0;
            n_spare = 0;
            n_refused_full = 0;
            n_refused_empty = 0;
        endfunction

        function bit is_full();
            return !empty && ((rear + 1) % cdq_pkg::DEPTH) == front;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        // Apply one command to the shadow deque and return the result it gives
        function cdq_pkg::cdq_out_t apply_command(cdq_pkg::cdq_in_t req);
            cdq_pkg::cdq_out_t res;
            res = '0;
            res.status = cdq_pkg::ST_DONE;
            case (req.command) inside
                cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
                    n_push++;
                    if (is_full()) begin
                        res.status = cdq_pkg::ST_FULL;
                        n_refused_full++;
                    end else if (empty) begin
                        front = 0;
                        rear  = 0;
                        empty = 1'b0;
                        words[0] = req.entry_value;
                    end else if (req.command == cdq_pkg::CMD_PUSH_FRONT) begin
                        front = (front + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
                        words[front] = req.entry_value;
                    end else begin
                        rear = (rear + 1) % cdq_pkg::DEPTH;
                        words[rear] = req.entry_value;
                    end
                end
                cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
                    n_pop++;
                    if (empty) begin
                        res.status = cdq_pkg::ST_EMPTY;
                        n_refused_empty++;
                    end else begin
                        res.data_out = words[req.command == cdq_pkg::CMD_POP_FRONT ? front : rear];
                        // Last entry gone: back to the reset position
                        if (front == rear) begin
                            empty = 1'b1;
                            front = 0;
                            rear  = 0;
                        end else if (req.command == cdq_pkg::CMD_POP_FRONT) begin
                            front = (front + 1) % cdq_pkg::DEPTH;
                        end else begin
                            rear = (rear + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
                        end
                    end
                end
                cdq_pkg::CMD_PEEK_FRONT, cdq_pkg::CMD_PEEK_REAR: begin
                    n_peek++;
                    if (empty) begin
                        res.status = cdq_pkg::ST_EMPTY;
                        n_refused_empty++;
                    end else begin
                        res.data_out = words[req.command == cdq_pkg::CMD_PEEK_FRONT ? front : rear];
                    end
                end
                default: begin
                    n_spare++;
                end
            endcase
            res.is_empty_flag = empty;
            res.is_full_flag  = is_full();
            return res;
        endfunction

        function void note_request(cdq_pkg::cdq_in_t req);
            awaited_results.push_back(apply_command(req));
        endfunction

        function void compare_field(string field, logic [cdq_pkg::DATA_W-1:0] want,
                                    logic [cdq_pkg::DATA_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(cdq_pkg::cdq_out_t got);
            cdq_pkg::cdq_out_t want;
            if (awaited_results.size() == 0) begin
                errors++;
                $display("%0t: result %h arrived with none awaited", $time, got);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("data_out", want.data_out, got.data_out);
            compare_field("status", cdq_pkg::DATA_W'(want.status),
                          cdq_pkg::DATA_W'(got.status));
            compare_field("is_empty_flag", cdq_pkg::DATA_W'(want.is_empty_flag),
                          cdq_pkg::DATA_W'(got.is_empty_flag));
            compare_field("is_full_flag", cdq_pkg::DATA_W'(want.is_full_flag),
                          cdq_pkg::DATA_W'(got.is_full_flag));
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    cdq_pkg::cdq_in_t  s_payload;
    logic              m_valid;
    logic              m_ready;
    cdq_pkg::cdq_out_t m_payload;

    bit              quiet_phase = 1'b0;
    deque_scoreboard board = new();

    circular_deque DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Offer one request, with an occasional idle burst before it, and note it once taken
    task automatic issue(input logic [cdq_pkg::CMD_W-1:0] cmd,
                         input logic [cdq_pkg::DATA_W-1:0] value);
        cdq_pkg::cdq_in_t req;
        req.command     = cmd;
        req.entry_value = value;
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
        board.note_request(req);
    endtask

    // Drop valid and hold until every awaited result has come back
    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
    endtask

    function automatic logic [cdq_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Reset, directed requests, then biased random traffic
    initial begin
        int burst_left;
        int mode;
        int roll;
        int push_pct;
        int pop_pct;
        logic [cdq_pkg::CMD_W-1:0] cmd;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Refusals and spare code on an empty deque
        issue(cdq_pkg::CMD_POP_FRONT, 32'h0000_0001);
        issue(cdq_pkg::CMD_POP_REAR, 32'h0000_0002);
        issue(cdq_pkg::CMD_PEEK_FRONT, 32'h0000_0003);
        issue(cdq_pkg::CMD_PEEK_REAR, 32'h0000_0004);
        issue(CMD_SPARE_6, 32'hFFFF_FFFF);
        // Fill from both ends, wrapping the front index
        issue(cdq_pkg::CMD_PUSH_REAR, 32'hFFFF_FFFF);
        issue(cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
        issue(cdq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        issue(cdq_pkg::CMD_PUSH_REAR, 32'h5555_5555);
        issue(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
        issue(cdq_pkg::CMD_PUSH_REAR, 32'h0000_0001);
        issue(cdq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        issue(cdq_pkg::CMD_PUSH_REAR, 32'hFFFF_FFFE);
        // Full: pushes refused, spare code leaves it alone
        issue(cdq_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
        issue(cdq_pkg::CMD_PUSH_REAR, 32'h8765_4321);
        issue(CMD_SPARE_7, 32'hDEAD_BEEF);
        issue(cdq_pkg::CMD_PEEK_FRONT, 32'h0);
        issue(cdq_pkg::CMD_PEEK_REAR, 32'h0);
        // Empty it again from alternating ends
        for (int i = 0; i < cdq_pkg::DEPTH; i++) begin
            issue((i % 2) ? cdq_pkg::CMD_POP_REAR : cdq_pkg::CMD_POP_FRONT, $urandom);
        end

        burst_left = 0;
        mode = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                pause_until_drained();
            end
            if (i == N_RANDOM - N_QUIET) begin
                quiet_phase = 1'b1;
            end
            // Switch between filling, emptying and balanced bursts
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 40);
                mode = $urandom_range(0, 2);
            end
            burst_left--;
            push_pct = (mode == 0) ? 60 : (mode == 1) ? 25 : 40;
            pop_pct  = (mode == 0) ? 25 : (mode == 1) ? 60 : 40;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
            end else if (roll < 3 + push_pct) begin
                cmd = ($urandom_range(0, 1) != 0) ? cdq_pkg::CMD_PUSH_REAR
                                                  : cdq_pkg::CMD_PUSH_FRONT;
            end else if (roll < 3 + push_pct + pop_pct) begin
                cmd = ($urandom_range(0, 1) != 0) ? cdq_pkg::CMD_POP_REAR
                                                  : cdq_pkg::CMD_POP_FRONT;
            end else begin
                cmd = ($urandom_range(0, 1) != 0) ? cdq_pkg::CMD_PEEK_REAR
                                                  : cdq_pkg::CMD_PEEK_FRONT;
            end
            issue(cmd, pick_word());
        end

        // Drain, allow for stray results, then report
        pause_until_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Sent %0d pushes, %0d pops, %0d peeks and %0d spare codes;",
                 board.n_push, board.n_pop, board.n_peek, board.n_spare);
        $display("refused %0d pushes when full and %0d pops or peeks when empty.",
                 board.n_refused_full, board.n_refused_empty);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Result side: stall in random bursts, none in the quiet phase
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0 && !quiet_phase) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = 0;
                if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 19);
                end
            end
        end
    end

    // Check every result taken at a rising edge
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                board.check_result(m_payload);
            end
        end
    end

    // Hold a hard limit on the run length
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
